@@ rtl/core/cpid_pkg.sv @@
// Package for the cascade PID controller: request types, widths, register
// indexes, controller state encoding and the command/status structs.
// No dependencies; every other file of the block imports it.
package cpid_pkg;

    // Sample and gain formats.
    localparam int SAMPLE_WIDTH   = 16;
    localparam int GAIN_FRAC_BITS = 8;
    localparam int GAIN_W         = 16;
    localparam int GAINS_W        = 3 * GAIN_W;
    localparam int OUT_W          = 16;

    // Configuration port.
    localparam int CFG_DATA_W  = GAINS_W;
    localparam int CFG_INDEX_W = 3;
    localparam int ILIM_W      = 23;
    localparam int OLIM_W      = 15;

    // Loop arithmetic widths.
    localparam int ERR_W  = SAMPLE_WIDTH + 1;
    localparam int DIFF_W = ERR_W + 1;
    localparam int ACC_W  = ILIM_W + 1;
    localparam int ASUM_W = ACC_W + 1;
    localparam int PP_W   = GAIN_W + ERR_W;
    localparam int PI_W   = GAIN_W + ACC_W;
    localparam int PD_W   = GAIN_W + DIFF_W;
    localparam int SUM_W  = PI_W + 2;
    localparam int SH_W   = SUM_W - GAIN_FRAC_BITS;

    // Input request: one control sample.
    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] outer_target;
        logic signed [SAMPLE_WIDTH-1:0] outer_feedback;
        logic signed [SAMPLE_WIDTH-1:0] inner_feedback;
    } sample_t;

    // Output request: one controller result.
    typedef struct packed {
        logic signed [OUT_W-1:0] drive;
        logic signed [OUT_W-1:0] outer_drive;
    } result_t;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_OUTER_GAINS  = 3'd0,
        CFG_INNER_GAINS  = 3'd1,
        CFG_OUTER_ILIM   = 3'd2,
        CFG_OUTER_OLIM   = 3'd3,
        CFG_INNER_ILIM   = 3'd4,
        CFG_INNER_OLIM   = 3'd5,
        CFG_CASCADE      = 3'd6
    } cfg_index_t;

    // Sequencer states: idle, error/integral step, multiply step, sum/clamp step.
    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_ERR  = 2'd1,
        ST_MUL  = 2'd2,
        ST_SUM  = 2'd3
    } state_t;

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic load_in;
        logic run_err;
        logic run_mul;
        logic save_outer;
        logic load_out;
        logic sel_inner;
    } cmd_t;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic cascade;
    } status_t;

endpackage

@@ rtl/core/cpid_ctrl.sv @@
// Sequencer of the cascade PID controller: runs the outer loop and, in
// cascade mode, the inner loop through the shared datapath steps.
// Depends on cpid_pkg.
module cpid_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             sample_valid,
    output logic             sample_stall,
    output logic             result_valid,
    input  logic             result_stall,
    input  cpid_pkg::status_t status,
    output cpid_pkg::cmd_t   cmd
);
    import cpid_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   loop_sel_reg;
    logic   loop_sel_next;
    logic   result_valid_reg;
    logic   result_valid_next;
    logic   out_free;
    logic   last_loop;

    // State, loop select and output valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            loop_sel_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            loop_sel_reg     <= loop_sel_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign out_free  = !result_valid_reg || !result_stall;
    assign last_loop = loop_sel_reg || !status.cascade;

    // Next state and datapath commands.
    always_comb
    begin
        state_next     = state_reg;
        loop_sel_next  = loop_sel_reg;
        cmd            = '0;
        cmd.sel_inner  = loop_sel_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample_valid)
                begin
                    cmd.load_in   = 1'b1;
                    loop_sel_next = 1'b0;
                    state_next    = ST_ERR;
                end
            end
            ST_ERR:
            begin
                cmd.run_err = 1'b1;
                state_next  = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.run_mul = 1'b1;
                state_next  = ST_SUM;
            end
            ST_SUM:
            begin
                if (!last_loop)
                begin
                    cmd.save_outer = 1'b1;
                    loop_sel_next  = 1'b1;
                    state_next     = ST_ERR;
                end
                else if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid: set on a new result, cleared when the request is taken.
    always_comb
    begin
        if (cmd.load_out)
            result_valid_next = 1'b1;
        else if (!result_stall)
            result_valid_next = 1'b0;
        else
            result_valid_next = result_valid_reg;
    end

    assign sample_stall = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;

`ifndef SYNTH
    // A new sample always starts with the outer loop.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_in |=> (state_reg == ST_ERR) && !loop_sel_reg)
        else $error("sample accepted but outer loop not started");

    // The outer result hands over to the inner loop in cascade mode.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SUM) && !loop_sel_reg && status.cascade
        |=> (state_reg == ST_ERR) && loop_sel_reg)
        else $error("inner loop not started after outer loop");

    // A loaded result is presented on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> result_valid_reg)
        else $error("result loaded but not valid");
`endif

endmodule

@@ rtl/core/cpid_datapath.sv @@
// Datapath of the cascade PID controller: configuration registers, loop
// state, error/integral step, three gain multipliers and the output clamp.
// Depends on cpid_pkg.
module cpid_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write_en,
    input  logic [cpid_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [cpid_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  cpid_pkg::sample_t                   sample,
    output cpid_pkg::result_t                   result,
    input  cpid_pkg::cmd_t                      cmd,
    output cpid_pkg::status_t                   status
);
    import cpid_pkg::*;

    // Configuration registers.
    logic [GAINS_W-1:0] outer_gains_reg;
    logic [GAINS_W-1:0] inner_gains_reg;
    logic [ILIM_W-1:0]  outer_ilim_reg;
    logic [OLIM_W-1:0]  outer_olim_reg;
    logic [ILIM_W-1:0]  inner_ilim_reg;
    logic [OLIM_W-1:0]  inner_olim_reg;
    logic               cascade_reg;

    // Loop state.
    logic signed [ERR_W-1:0] outer_prev_reg;
    logic signed [ACC_W-1:0] outer_acc_reg;
    logic signed [ERR_W-1:0] inner_prev_reg;
    logic signed [ACC_W-1:0] inner_acc_reg;

    // Step registers.
    sample_t                  sample_reg;
    logic signed [ERR_W-1:0]  e_reg;
    logic signed [DIFF_W-1:0] d_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [PP_W-1:0]   pp_reg;
    logic signed [PI_W-1:0]   pi_reg;
    logic signed [PD_W-1:0]   pd_reg;
    logic signed [OUT_W-1:0]  outer_out_reg;
    result_t                  result_reg;

    // Combinational step values.
    logic signed [ERR_W-1:0]  tgt_s;
    logic signed [ERR_W-1:0]  fb_s;
    logic signed [ERR_W-1:0]  e_next;
    logic signed [ERR_W-1:0]  prev_s;
    logic signed [DIFF_W-1:0] d_next;
    logic signed [ACC_W-1:0]  acc_old;
    logic signed [ASUM_W-1:0] acc_sum;
    logic signed [ASUM_W-1:0] ilim_s;
    logic signed [ACC_W-1:0]  acc_next;
    logic [GAINS_W-1:0]       gains;
    logic signed [GAIN_W-1:0] kp;
    logic signed [GAIN_W-1:0] ki;
    logic signed [GAIN_W-1:0] kd;
    logic signed [PP_W-1:0]   pp_next;
    logic signed [PI_W-1:0]   pi_next;
    logic signed [PD_W-1:0]   pd_next;
    logic signed [SUM_W-1:0]  sum;
    logic signed [SH_W-1:0]   sh;
    logic signed [SH_W-1:0]   olim_s;
    logic signed [OUT_W-1:0]  loop_out;

    // Configuration write decoder.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outer_gains_reg <= '0;
            inner_gains_reg <= '0;
            outer_ilim_reg  <= '0;
            outer_olim_reg  <= '0;
            inner_ilim_reg  <= '0;
            inner_olim_reg  <= '0;
            cascade_reg     <= 1'b1;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_OUTER_GAINS: outer_gains_reg <= cfg_data[GAINS_W-1:0];
                CFG_INNER_GAINS: inner_gains_reg <= cfg_data[GAINS_W-1:0];
                CFG_OUTER_ILIM:  outer_ilim_reg  <= cfg_data[ILIM_W-1:0];
                CFG_OUTER_OLIM:  outer_olim_reg  <= cfg_data[OLIM_W-1:0];
                CFG_INNER_ILIM:  inner_ilim_reg  <= cfg_data[ILIM_W-1:0];
                CFG_INNER_OLIM:  inner_olim_reg  <= cfg_data[OLIM_W-1:0];
                CFG_CASCADE:     cascade_reg     <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    assign status.cascade = cascade_reg;

    // Error, derivative and clamped integral of the selected loop.
    always_comb
    begin
        if (cmd.sel_inner)
        begin
            tgt_s   = ERR_W'(outer_out_reg);
            fb_s    = ERR_W'(sample_reg.inner_feedback);
            prev_s  = inner_prev_reg;
            acc_old = inner_acc_reg;
            ilim_s  = ASUM_W'($signed({1'b0, inner_ilim_reg}));
        end
        else
        begin
            tgt_s   = ERR_W'(sample_reg.outer_target);
            fb_s    = ERR_W'(sample_reg.outer_feedback);
            prev_s  = outer_prev_reg;
            acc_old = outer_acc_reg;
            ilim_s  = ASUM_W'($signed({1'b0, outer_ilim_reg}));
        end
        e_next  = tgt_s - fb_s;
        d_next  = DIFF_W'(e_next) - DIFF_W'(prev_s);
        acc_sum = ASUM_W'(acc_old) + ASUM_W'(e_next);
        if (acc_sum > ilim_s)
            acc_next = ACC_W'(ilim_s);
        else if (acc_sum < -ilim_s)
            acc_next = ACC_W'(-ilim_s);
        else
            acc_next = ACC_W'(acc_sum);
    end

    // Gain products of the selected loop.
    assign gains   = cmd.sel_inner ? inner_gains_reg : outer_gains_reg;
    assign kp      = gains[GAIN_W-1:0];
    assign ki      = gains[2*GAIN_W-1:GAIN_W];
    assign kd      = gains[3*GAIN_W-1:2*GAIN_W];
    assign pp_next = kp * e_reg;
    assign pi_next = ki * acc_reg;
    assign pd_next = kd * d_reg;

    // Sum, floor shift by dropping fraction bits, then output clamp.
    always_comb
    begin
        sum    = SUM_W'(pp_reg) + SUM_W'(pi_reg) + SUM_W'(pd_reg);
        sh     = sum[SUM_W-1:GAIN_FRAC_BITS];
        olim_s = cmd.sel_inner ? SH_W'($signed({1'b0, inner_olim_reg}))
                               : SH_W'($signed({1'b0, outer_olim_reg}));
        if (sh > olim_s)
            loop_out = OUT_W'(olim_s);
        else if (sh < -olim_s)
            loop_out = OUT_W'(-olim_s);
        else
            loop_out = OUT_W'(sh);
    end

    // Loop state updates once per loop run.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outer_prev_reg <= '0;
            outer_acc_reg  <= '0;
            inner_prev_reg <= '0;
            inner_acc_reg  <= '0;
        end
        else if (cmd.run_err)
        begin
            if (cmd.sel_inner)
            begin
                inner_prev_reg <= e_next;
                inner_acc_reg  <= acc_next;
            end
            else
            begin
                outer_prev_reg <= e_next;
                outer_acc_reg  <= acc_next;
            end
        end
    end

    // Payload and step registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
            sample_reg <= sample;
        if (cmd.run_err)
        begin
            e_reg   <= e_next;
            d_reg   <= d_next;
            acc_reg <= acc_next;
        end
        if (cmd.run_mul)
        begin
            pp_reg <= pp_next;
            pi_reg <= pi_next;
            pd_reg <= pd_next;
        end
        if (cmd.save_outer)
            outer_out_reg <= loop_out;
        if (cmd.load_out)
        begin
            result_reg.drive       <= loop_out;
            result_reg.outer_drive <= cmd.sel_inner ? outer_out_reg : loop_out;
        end
    end

    assign result = result_reg;

`ifndef SYNTH
    // The inner loop state is untouched while the outer loop runs.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.run_err && !cmd.sel_inner |=> $stable(inner_acc_reg)
                                          && $stable(inner_prev_reg))
        else $error("inner state changed during outer loop step");

    // The outer loop state only moves on an outer error step.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.run_err && !cmd.sel_inner) |=> $stable(outer_acc_reg)
                                             && $stable(outer_prev_reg))
        else $error("outer state changed outside its error step");
`endif

endmodule

@@ rtl/core/cascade_pid_controller_top.sv @@
// Cascade PID controller, top level: ties the sequencer to the datapath.
// Depends on cpid_pkg, cpid_ctrl and cpid_datapath.
//
// Usage:
//   sample channel (sample_valid / sample_stall / sample) carries one request
//   per control period: outer target, outer feedback and inner feedback.
//   result channel (result_valid / result_stall / result) returns one request
//   per sample: drive and the clamped outer loop output.
//   Configuration is a plain write port (cfg_write_en, cfg_index, cfg_data);
//   write it only while no sample is in flight. Unknown indexes are ignored.
// Sequencing:
//   Each loop takes three datapath steps (error and integral, gain multiply,
//   sum and clamp) on one shared set of three multipliers. The result is
//   loaded after the sum and clamp step of the outer loop in single mode and
//   of the inner loop in cascade mode; no new sample is taken until then.
//   A finished result waits in the output register while the next sample is
//   taken; if that register is still full at the end of the next sample,
//   the sequencer holds until the receiver releases result_stall.
// Reset:
//   Loop errors and integrals clear to zero, all gains and limits to zero,
//   cascade mode on, no result pending.
module cascade_pid_controller_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                sample_valid,
    output logic                                sample_stall,
    input  cpid_pkg::sample_t                   sample,
    output logic                                result_valid,
    input  logic                                result_stall,
    output cpid_pkg::result_t                   result,
    input  logic                                cfg_write_en,
    input  logic [cpid_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [cpid_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import cpid_pkg::*;

    cmd_t    cmd;
    status_t status;

    // Sequencer.
    cpid_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .cmd          (cmd)
    );

    // Datapath.
    cpid_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample       (sample),
        .result       (result),
        .cmd          (cmd),
        .status       (status)
    );

endmodule

@@ verif/cpid_checker.sv @@
`timescale 1ns / 100ps
// Checker for the cascade PID controller: watches the sample, result and
// register write ports, predicts each result and compares it. Uses cpid_pkg.
module cpid_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             sample_valid,
    input  logic                             sample_stall,
    input  cpid_pkg::sample_t                sample,
    input  logic                             result_valid,
    input  logic                             result_stall,
    input  cpid_pkg::result_t                result,
    input  logic                             cfg_write_en,
    input  logic [cpid_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [cpid_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                               mismatches,
    output int                               outstanding
);
    import cpid_pkg::*;

    localparam int OUTER_LOOP = 0;
    localparam int INNER_LOOP = 1;

    // Shadow copy of the register file.
    logic [GAINS_W-1:0] outer_gains_r;
    logic [GAINS_W-1:0] inner_gains_r;
    logic [ILIM_W-1:0]  outer_ilim_r;
    logic [ILIM_W-1:0]  inner_ilim_r;
    logic [OLIM_W-1:0]  outer_olim_r;
    logic [OLIM_W-1:0]  inner_olim_r;
    logic               cascade_r;

    // Loop state, indexed by loop.
    logic signed [ERR_W-1:0] prev_err_r [2];
    logic signed [ACC_W-1:0] accum_r    [2];

    // Results still owed by the block, oldest first.
    result_t drive_expect_q [$];

    function automatic longint clamp_mag(input longint v, input longint lim);
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    // One positional PID step of loop lp; updates that loop's error and integral.
    function automatic longint pid_step(
        input int                 lp,
        input logic [GAINS_W-1:0] gains,
        input logic [ILIM_W-1:0]  ilim,
        input logic [OLIM_W-1:0]  olim,
        input longint             target,
        input longint             fb
    );
        longint kp;
        longint ki;
        longint kd;
        longint err;
        longint diff;
        longint acc;
        longint total;
        kp   = longint'($signed(gains[GAIN_W-1:0]));
        ki   = longint'($signed(gains[2*GAIN_W-1:GAIN_W]));
        kd   = longint'($signed(gains[3*GAIN_W-1:2*GAIN_W]));
        err  = target - fb;
        diff = err - longint'(prev_err_r[lp]);
        acc  = clamp_mag(longint'(accum_r[lp]) + err, longint'(ilim));
        prev_err_r[lp] = err[ERR_W-1:0];
        accum_r[lp]    = acc[ACC_W-1:0];
        total = kp * err + ki * acc + kd * diff;
        // Arithmetic shift of a signed value rounds toward minus infinity.
        return clamp_mag(total >>> GAIN_FRAC_BITS, longint'(olim));
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        longint  outer_out;
        longint  drive_out;
        if (!rst_n)
        begin
            outer_gains_r = '0;
            inner_gains_r = '0;
            outer_ilim_r  = '0;
            inner_ilim_r  = '0;
            outer_olim_r  = '0;
            inner_olim_r  = '0;
            cascade_r     = 1'b1;
            for (int i = 0; i < 2; i++)
            begin
                prev_err_r[i] = '0;
                accum_r[i]    = '0;
            end
            drive_expect_q.delete();
            mismatches  = 0;
            outstanding = 0;
        end
        else
        begin
            // Register writes; unknown indexes are dropped.
            if (cfg_write_en)
            begin
                case (cfg_index)
                    CFG_OUTER_GAINS: outer_gains_r = cfg_data[GAINS_W-1:0];
                    CFG_INNER_GAINS: inner_gains_r = cfg_data[GAINS_W-1:0];
                    CFG_OUTER_ILIM:  outer_ilim_r  = cfg_data[ILIM_W-1:0];
                    CFG_OUTER_OLIM:  outer_olim_r  = cfg_data[OLIM_W-1:0];
                    CFG_INNER_ILIM:  inner_ilim_r  = cfg_data[ILIM_W-1:0];
                    CFG_INNER_OLIM:  inner_olim_r  = cfg_data[OLIM_W-1:0];
                    CFG_CASCADE:     cascade_r     = cfg_data[0];
                    default: ;
                endcase
            end

            // Compare an accepted result against the oldest prediction.
            if (result_valid && !result_stall)
            begin
                if (drive_expect_q.size() == 0)
                begin
                    $error("result request with no sample outstanding: drive %0d",
                           result.drive);
                    mismatches++;
                end
                else
                begin
                    want = drive_expect_q.pop_front();
                    check_field("drive", want.drive, result.drive);
                    check_field("outer_drive", want.outer_drive, result.outer_drive);
                end
            end

            // Predict the result of an accepted sample.
            if (sample_valid && !sample_stall)
            begin
                outer_out = pid_step(OUTER_LOOP, outer_gains_r, outer_ilim_r,
                                     outer_olim_r,
                                     longint'($signed(sample.outer_target)),
                                     longint'($signed(sample.outer_feedback)));
                if (cascade_r)
                    drive_out = pid_step(INNER_LOOP, inner_gains_r, inner_ilim_r,
                                         inner_olim_r, outer_out,
                                         longint'($signed(sample.inner_feedback)));
                else
                    drive_out = outer_out;
                want.drive       = drive_out[OUT_W-1:0];
                want.outer_drive = outer_out[OUT_W-1:0];
                drive_expect_q.push_back(want);
            end

            outstanding = drive_expect_q.size();
        end
    end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// Testbench top for the cascade PID controller: clock, reset, sample and
// register stimulus, result back-pressure and the verdict.
// Depends on cpid_pkg, cascade_pid_controller_top and cpid_checker.
module tb_top;
    import cpid_pkg::*;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int NUM_PHASES      = 6;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int DRAIN_CYCLES    = 20;

    // Index with no register behind it.
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_INDEX = 3'd7;

    // Q8.8 gain values.
    localparam logic [GAIN_W-1:0] GAIN_ONE  = 16'h0100;
    localparam logic [GAIN_W-1:0] GAIN_HALF = 16'h0080;
    localparam logic [GAIN_W-1:0] GAIN_NEG1 = 16'hFF00;
    localparam logic [GAIN_W-1:0] GAIN_MAX  = 16'h7FFF;
    localparam logic [GAIN_W-1:0] GAIN_MIN  = 16'h8000;

    localparam logic [CFG_DATA_W-1:0] ILIM_MAX = (48'h1 << ILIM_W) - 48'h1;
    localparam logic [CFG_DATA_W-1:0] OLIM_MAX = (48'h1 << OLIM_W) - 48'h1;

    logic                   clk;
    logic                   rst_n;
    logic                   sample_valid;
    logic                   sample_stall;
    sample_t                sample;
    logic                   result_valid;
    logic                   result_stall;
    result_t                result;
    logic                   cfg_write_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    int                     mismatches;
    int                     outstanding;

    // Sender idling and the slowly moving process the samples follow.
    logic tx_quiet;
    int   plant_target;
    int   plant_fb;
    int   plant_inner;

    cascade_pid_controller_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    cpid_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog.
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("FAIL cascade_pid_controller_top");
        $finish;
    end

    // Result back-pressure: bursts of stall and release, long holds now and
    // then, and stretches with no stall at all.
    initial
    begin
        int   hold;
        int   r;
        logic rx_quiet;
        hold     = 0;
        rx_quiet = 1'b0;
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                hold--;
            end
            else
            begin
                if ($urandom_range(0, 49) == 0)
                    rx_quiet = ~rx_quiet;
                r = $urandom_range(0, 99);
                if (rx_quiet)
                begin
                    result_stall <= 1'b0;
                    hold = 20;
                end
                else if (r < 60)
                begin
                    result_stall <= 1'b0;
                    hold = $urandom_range(0, 3);
                end
                else if (r < 93)
                begin
                    result_stall <= 1'b1;
                    hold = $urandom_range(0, 2);
                end
                else
                begin
                    result_stall <= 1'b1;
                    hold = $urandom_range(10, 40);
                end
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (tx_quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int sat16(input int v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    function automatic int pick_extreme();
        case ($urandom_range(0, 3))
            0:       return -32768;
            1:       return 32767;
            2:       return 0;
            default: return -1;
        endcase
    endfunction

    function automatic sample_t make_sample(input int t, input int f, input int i);
        sample_t s;
        s.outer_target   = 16'(t);
        s.outer_feedback = 16'(f);
        s.inner_feedback = 16'(i);
        return s;
    endfunction

    // Mostly a feedback signal settling toward a target that jumps now and
    // then; some full-range noise and some field extremes mixed in.
    function automatic sample_t next_sample();
        int r;
        int step;
        r = $urandom_range(0, 99);
        if (r < 5)
            return make_sample(pick_extreme(), pick_extreme(), pick_extreme());
        if (r < 20)
            return make_sample(int'($urandom), int'($urandom), int'($urandom));
        if ($urandom_range(0, 15) == 0)
        begin
            if ($urandom_range(0, 1))
                plant_target = int'($urandom_range(0, 65535)) - 32768;
            else
                plant_target = int'($urandom_range(0, 4000)) - 2000;
        end
        step        = (plant_target - plant_fb) / 4 + int'($urandom_range(0, 64)) - 32;
        plant_fb    = sat16(plant_fb + step);
        plant_inner = sat16(plant_inner + int'($urandom_range(0, 200)) - 100);
        return make_sample(plant_target, plant_fb, plant_inner);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pack_gains(
        input logic [GAIN_W-1:0] kp,
        input logic [GAIN_W-1:0] ki,
        input logic [GAIN_W-1:0] kd
    );
        return {kd, ki, kp};
    endfunction

    function automatic logic [GAIN_W-1:0] rand_gain();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return 16'(int'($urandom_range(0, 1024)) - 512);
        if (r < 6)
            return 16'(int'($urandom_range(0, 128)) - 64);
        if (r < 8)
            return 16'($urandom);
        case ($urandom_range(0, 3))
            0:       return GAIN_MAX;
            1:       return GAIN_MIN;
            2:       return GAIN_ONE;
            default: return '0;
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_limit(input logic [CFG_DATA_W-1:0] lim_max);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return lim_max;
        if (r < 6)
            return CFG_DATA_W'($urandom_range(1, 2000));
        return CFG_DATA_W'($urandom) & lim_max;
    endfunction

    // Random bits above a narrow register's width must not matter.
    function automatic logic [CFG_DATA_W-1:0] with_noise(
        input logic [CFG_DATA_W-1:0] v,
        input logic [CFG_DATA_W-1:0] mask
    );
        logic [CFG_DATA_W-1:0] r;
        r = {$urandom, $urandom};
        return (r & ~mask) | (v & mask);
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= data;
        @(negedge clk);
        cfg_write_en <= 1'b0;
    endtask

    task automatic set_config(
        input logic [CFG_DATA_W-1:0] outer_gains,
        input logic [CFG_DATA_W-1:0] inner_gains,
        input logic [CFG_DATA_W-1:0] outer_ilim,
        input logic [CFG_DATA_W-1:0] outer_olim,
        input logic [CFG_DATA_W-1:0] inner_ilim,
        input logic [CFG_DATA_W-1:0] inner_olim,
        input logic                  cascade
    );
        write_reg(CFG_OUTER_GAINS, outer_gains);
        write_reg(CFG_INNER_GAINS, inner_gains);
        write_reg(CFG_OUTER_ILIM, with_noise(outer_ilim, ILIM_MAX));
        write_reg(CFG_OUTER_OLIM, with_noise(outer_olim, OLIM_MAX));
        write_reg(CFG_INNER_ILIM, with_noise(inner_ilim, ILIM_MAX));
        write_reg(CFG_INNER_OLIM, with_noise(inner_olim, OLIM_MAX));
        write_reg(CFG_CASCADE, with_noise({47'd0, cascade}, 48'h1));
    endtask

    // Present one sample request after a random gap and hold it until taken.
    task automatic send_sample(input sample_t s);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= s;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
    endtask

    task automatic send_fields(input int t, input int f, input int i);
        send_sample(make_sample(t, f, i));
    endtask

    // Stop sending and wait for every outstanding result.
    task automatic wait_idle();
        @(negedge clk);
        sample_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    initial
    begin
        rst_n        = 1'b0;
        sample_valid = 1'b0;
        sample       = '0;
        cfg_write_en = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        tx_quiet     = 1'b0;
        plant_target = 0;
        plant_fb     = 0;
        plant_inner  = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: zero gains and limits in cascade mode give zero out.
        // A write to the spare index must change nothing.
        write_reg(CFG_SPARE_INDEX, {$urandom, $urandom});
        send_fields(32767, -32768, 32767);
        send_fields(-32768, 32767, -32768);
        send_fields(0, 0, 0);

        // Single mode at full limits: inner feedback has no effect.
        wait_idle();
        set_config(pack_gains(GAIN_ONE, GAIN_HALF, GAIN_NEG1),
                   pack_gains(GAIN_HALF, GAIN_ONE, '0),
                   ILIM_MAX, OLIM_MAX, ILIM_MAX, OLIM_MAX, 1'b0);
        send_fields(32767, -32768, -32768);
        send_fields(32767, -32768, 32767);
        send_fields(-32768, 32767, 0);
        send_fields(-32768, 32767, -1);
        send_fields(0, 0, 12345);
        send_fields(100, -100, -32768);

        // Cascade with the extreme gains.
        wait_idle();
        set_config(pack_gains(GAIN_MAX, GAIN_MIN, GAIN_MAX),
                   pack_gains(GAIN_MIN, GAIN_MAX, GAIN_MIN),
                   ILIM_MAX, OLIM_MAX, ILIM_MAX, OLIM_MAX, 1'b1);
        send_fields(32767, -32768, -32768);
        send_fields(-32768, 32767, 32767);
        send_fields(32767, -32768, 32767);
        send_fields(-1, 0, -32768);
        send_fields(0, 0, 0);

        // Zero outer integral limit and zero inner output limit.
        wait_idle();
        set_config(pack_gains(GAIN_ONE, GAIN_ONE, GAIN_ONE),
                   pack_gains(GAIN_ONE, GAIN_ONE, GAIN_ONE),
                   '0, 48'd1000, 48'd300, '0, 1'b1);
        send_fields(5000, 1000, -200);
        send_fields(-5000, 1000, 200);
        send_fields(32767, -32768, 0);

        // Smallest nonzero limits.
        wait_idle();
        set_config(pack_gains(GAIN_MAX, GAIN_MAX, GAIN_MIN),
                   pack_gains(GAIN_MAX, GAIN_MIN, GAIN_MAX),
                   48'd1, 48'd1, 48'd1, 48'd1, 1'b1);
        send_fields(32767, -32768, 32767);
        send_fields(-32768, 32767, -32768);
        send_fields(10, 20, 30);

        // Random phases, each under its own settings.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_idle();
            set_config(pack_gains(rand_gain(), rand_gain(), rand_gain()),
                       pack_gains(rand_gain(), rand_gain(), rand_gain()),
                       rand_limit(ILIM_MAX), rand_limit(OLIM_MAX),
                       rand_limit(ILIM_MAX), rand_limit(OLIM_MAX),
                       (p == 0) ? 1'b1 : (p == 1) ? 1'b0 : 1'($urandom_range(0, 1)));
            tx_quiet = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                // Let the block drain completely in the middle of a phase.
                if (k == ITEMS_PER_PHASE / 2 && (p == 0 || $urandom_range(0, 1)))
                    wait_idle();
                send_sample(next_sample());
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("PASS cascade_pid_controller_top");
        else
            $display("FAIL cascade_pid_controller_top");
        $finish;
    end

endmodule
